// ===== hdl/sha256_pkg.sv =====
// Package with SHA-256 constants, state encoding and round functions.
package sha256_pkg;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_BYTES = 6'b000010,
        ST_PAD   = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_ADD   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    // Controls handed from the sequencer to the round unit.
    typedef struct packed {
        logic       load;
        logic       step;
        logic       add;
        logic       reinit;
        logic [5:0] round;
    } round_ctrl_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== hdl/sha256_message_hash.sv =====
// Top level of the SHA-256 message hasher: input buffering, padding and sequencing.
// Usage: the message arrives on the s_ channel as big-endian 32-bit words,
// one word per beat. s_tdata carries the word and the count of valid leading
// bytes, s_tlast marks the final word. Each beat places its bytes into a
// 64-byte block buffer at one byte per cycle; when the buffer fills, the
// shared round unit runs the 64 rounds one per cycle, then an add step adds the
// result into the chain hash. s_tready is low while a word is in work.
// A last word also pads at one byte per cycle, pausing while a full block
// is hashed (up to 64 bytes, closing one or two blocks), then presents
// eight digest beats on m_, word 0 first, m_tlast on the eighth. If the
// receiver holds m_tready low, the current digest beat holds and nothing
// else moves. After the eighth beat the block re-arms with the initial
// hash and a zero length. Reset (aresetn low, synchronous) returns to
// idle with the initial hash loaded; the block buffer is cleared at reset
// and as each block is consumed.
module sha256_message_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // message_word[31:0], byte_count[34:32], zero fill
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
    output logic        m_tlast    // last_word
);

    sha256_pkg::state_t      state_reg, state_next;
    sha256_pkg::round_ctrl_t ctrl;

    logic [31:0] word_reg;
    logic [2:0]  count_reg;
    logic        last_reg;
    logic [5:0]  pos_reg;
    logic [63:0] len_reg;
    logic [5:0]  round_reg;
    logic [2:0]  out_idx_reg;
    logic        final_reg;   // pad byte of the last word still to be placed
    logic [31:0] blk_reg [16];
    logic [31:0] hash_word;

    logic        put_en;
    logic [7:0]  put_byte;
    logic [4:0]  shift;

    assign s_tready = (state_reg == sha256_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == sha256_pkg::ST_OUT);
    assign m_tdata  = {5'd0, out_idx_reg, hash_word};
    assign m_tlast  = (out_idx_reg == 3'd7);

    // Round unit controls.
    always_comb begin
        ctrl.load   = 1'b0;
        ctrl.step   = (state_reg == sha256_pkg::ST_ROUND);
        ctrl.add    = (state_reg == sha256_pkg::ST_ADD);
        ctrl.reinit = m_tvalid && m_tready && m_tlast;
        ctrl.round  = round_reg;
        // Working variables load as the buffer fills or padding reaches the length field, in the cycle before round 0.
        if (put_en && pos_reg == 6'd63) ctrl.load = 1'b1;
        if (state_reg == sha256_pkg::ST_PAD && pos_reg == sha256_pkg::LEN_POS
            && !put_en) ctrl.load = 1'b1;
    end

    sha256_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .block_word(blk_reg[round_reg[3:0]]),
        .hash_sel  (out_idx_reg),
        .hash_word (hash_word)
    );

    // Byte placement: message bytes, then the pad byte and zeros.
    always_comb begin
        put_en   = 1'b0;
        put_byte = 8'd0;
        if (state_reg == sha256_pkg::ST_BYTES && count_reg != 3'd0) begin
            put_en   = 1'b1;
            put_byte = word_reg[31:24];
        end else if (state_reg == sha256_pkg::ST_PAD && !final_reg
                     && pos_reg != sha256_pkg::LEN_POS) begin
            put_en   = 1'b1;
        end else if (state_reg == sha256_pkg::ST_PAD && final_reg) begin
            put_en   = 1'b1;
            put_byte = sha256_pkg::PAD_BYTE;
        end
        shift = 5'(24 - 8 * pos_reg[1:0]);
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sha256_pkg::ST_IDLE:
                if (s_tvalid) state_next = sha256_pkg::ST_BYTES;
            sha256_pkg::ST_BYTES:
                if (put_en && pos_reg == 6'd63) state_next = sha256_pkg::ST_ROUND;
                else if (count_reg == 3'd0)
                    state_next = last_reg ? sha256_pkg::ST_PAD : sha256_pkg::ST_IDLE;
            sha256_pkg::ST_PAD:
                if (put_en && pos_reg == 6'd63) state_next = sha256_pkg::ST_ROUND;
                else if (!put_en) state_next = sha256_pkg::ST_ROUND;
            sha256_pkg::ST_ROUND:
                if (round_reg == 6'd63) state_next = sha256_pkg::ST_ADD;
            sha256_pkg::ST_ADD:
                // Only the closing block leaves the fill position at the length field.
                if (last_reg && count_reg == 3'd0
                    && (final_reg || pos_reg != sha256_pkg::LEN_POS))
                    state_next = sha256_pkg::ST_PAD;
                else if (last_reg && count_reg == 3'd0)
                    state_next = sha256_pkg::ST_OUT;
                else if (count_reg != 3'd0)
                    state_next = sha256_pkg::ST_BYTES;
                else
                    state_next = sha256_pkg::ST_IDLE;
            sha256_pkg::ST_OUT:
                if (m_tready && m_tlast) state_next = sha256_pkg::ST_IDLE;
            default: state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sha256_pkg::ST_IDLE;
            pos_reg     <= 6'd0;
            len_reg     <= 64'd0;
            round_reg   <= 6'd0;
            out_idx_reg <= 3'd0;
            final_reg   <= 1'b0;
            count_reg   <= 3'd0;
            last_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Capture an input beat, clamping the byte count at four.
            if (s_tvalid && s_tready) begin
                word_reg  <= s_tdata[31:0];
                count_reg <= (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];
                last_reg  <= s_tlast;
                final_reg <= s_tlast;
            end
            // One byte per cycle into the buffer.
            if (put_en) begin
                pos_reg <= pos_reg + 6'd1;
                if (state_reg == sha256_pkg::ST_BYTES) begin
                    word_reg  <= {word_reg[23:0], 8'd0};
                    count_reg <= count_reg - 3'd1;
                    len_reg   <= len_reg + 64'd8;
                end else if (final_reg) begin
                    final_reg <= 1'b0;
                end
            end
            // Round counter.
            if (state_reg == sha256_pkg::ST_ROUND) round_reg <= round_reg + 6'd1;
            // Digest beats.
            if (m_tvalid && m_tready) begin
                out_idx_reg <= out_idx_reg + 3'd1;
                if (m_tlast) begin
                    pos_reg   <= 6'd0;
                    len_reg   <= 64'd0;
                    last_reg  <= 1'b0;
                end
            end
        end
    end

    // Block buffer: bytes are merged in, the length lands in the last two words
    // at the closing block, and each word clears as its round consumes it.
    always_ff @(posedge aclk) begin
        if (put_en) begin
            blk_reg[pos_reg[5:2]] <= (blk_reg[pos_reg[5:2]] & ~(32'hff << shift))
                                     | ({24'd0, put_byte} << shift);
        end else if (state_reg == sha256_pkg::ST_PAD) begin
            blk_reg[14] <= len_reg[63:32];
            blk_reg[15] <= len_reg[31:0];
        end
        if (state_reg == sha256_pkg::ST_ROUND && round_reg < 6'd16) begin
            blk_reg[round_reg[3:0]] <= 32'd0;
        end
        if (!aresetn || (m_tvalid && m_tready && m_tlast)) begin
            for (int j = 0; j < 16; j++) blk_reg[j] <= 32'd0;
        end
    end

endmodule

// ===== hdl/sha256_round.sv =====
// Shared SHA-256 round unit: working variables, schedule window and chain hash.
module sha256_round (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  sha256_pkg::round_ctrl_t  ctrl,
    input  logic [31:0]              block_word,
    input  logic [2:0]               hash_sel,
    output logic [31:0]              hash_word
);

    logic [31:0] hash_reg [8];
    logic [31:0] var_reg  [8];
    logic [31:0] win_reg  [16];

    logic [31:0] w_t, s0, s1, t1, t2, ch, maj, ep0, ep1;
    logic [31:0] a, b, c, e, f, g, h, w2, w7, w15, w16;

    always_comb begin
        a = var_reg[0]; b = var_reg[1]; c = var_reg[2];
        e = var_reg[4]; f = var_reg[5]; g = var_reg[6]; h = var_reg[7];
        w2  = win_reg[4'(ctrl.round - 6'd2)];
        w7  = win_reg[4'(ctrl.round - 6'd7)];
        w15 = win_reg[4'(ctrl.round - 6'd15)];
        w16 = win_reg[ctrl.round[3:0]];
        s1 = sha256_pkg::rotr(w2, 17) ^ sha256_pkg::rotr(w2, 19) ^ (w2 >> 10);
        s0 = sha256_pkg::rotr(w15, 7) ^ sha256_pkg::rotr(w15, 18) ^ (w15 >> 3);
        // Message schedule word for this round.
        w_t = (ctrl.round < 6'd16) ? block_word : s1 + w7 + s0 + w16;
        ep1 = sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11) ^ sha256_pkg::rotr(e, 25);
        ep0 = sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22);
        ch  = (e & f) ^ (~e & g);
        maj = (a & b) ^ (a & c) ^ (b & c);
        t1 = h + ep1 + ch + sha256_pkg::ROUND_K[ctrl.round] + w_t;
        t2 = ep0 + maj;
    end

    assign hash_word = hash_reg[hash_sel];

    // Working variables and schedule window update once per round.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            for (int j = 0; j < 8; j++) var_reg[j] <= hash_reg[j];
        end else if (ctrl.step) begin
            win_reg[ctrl.round[3:0]] <= w_t;
            var_reg[7] <= g;
            var_reg[6] <= f;
            var_reg[5] <= e;
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= c;
            var_reg[2] <= b;
            var_reg[1] <= a;
            var_reg[0] <= t1 + t2;
        end
    end

    // Chain hash: reset to the initial values (also on re-arm), accumulate after each block.
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.reinit) begin
            for (int j = 0; j < 8; j++) hash_reg[j] <= sha256_pkg::H_INIT[j];
        end else if (ctrl.add) begin
            for (int j = 0; j < 8; j++) hash_reg[j] <= hash_reg[j] + var_reg[j];
        end
    end

endmodule

// ===== hdl/sha256_checker.sv =====
// Port-level assertions for the SHA-256 message hasher, bound to the top level.
module sha256_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // Input and output are never open at once.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("s_tready while digest pending");

    // The last flag marks exactly word index seven.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7)))
        else $error("m_tlast mismatch");

    // Digest beats count up by one.
    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid
        && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1))
        else $error("digest index skipped");

    // A stalled beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("digest beat changed under stall");

endmodule

bind sha256_message_hash sha256_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
